FILE: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked property, ignored while reset is low
`define PWIS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked property, checked during reset too
`define PWIS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PWIS_ASSERT(lbl, clk, rst_n, prop, msg)
`define PWIS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: src/pwis_pkg.sv
package pwis_pkg;

  // default data format
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // fixed field widths
  localparam int DT_W      = 16;
  localparam int RATIO_W   = 17;
  localparam int REG_IDX_W = 3;
  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(65536);

  // scaling of the integral on a large opposing error: 4/5
  localparam logic [DT_W-1:0] SCALE_DEN = DT_W'(5);

  // configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_DRIVE_MIN = 3'd3,
    REG_DRIVE_MAX = 3'd4,
    REG_ACCUM_MIN = 3'd5,
    REG_ACCUM_MAX = 3'd6,
    REG_SEP_RATIO = 3'd7
  } reg_idx_t;

  // control into a serial multiplier
  typedef struct packed {
    logic start;
    logic sh16;
  } mul_ctl_t;

  // status of a serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

FILE: src/pwis_if.sv
// input channel: one control step request per beat
interface pwis_in_if import pwis_pkg::*; #(
  parameter int W = DATA_WIDTH_DEF
) ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic signed [W-1:0] target;
  logic signed [W-1:0] sample;
  logic [DT_W-1:0]     step_time;

  modport source (output valid, mode, target, sample, step_time, input ready);
  modport sink   (input valid, mode, target, sample, step_time, output ready);
endinterface

// result channel: one drive value per beat
interface pwis_out_if import pwis_pkg::*; #(
  parameter int W = DATA_WIDTH_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] drive;
  logic                clamped;
  logic                bad_step;

  modport source (output valid, drive, clamped, bad_step, input ready);
  modport sink   (input valid, drive, clamped, bad_step, output ready);
endinterface

FILE: src/pwis_mul.sv
// bit-serial shift-add multiplier with shift, truncation and saturation
module pwis_mul import pwis_pkg::*; #(
  parameter int W = DATA_WIDTH_DEF,
  parameter int F = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mul_ctl_t            ctl,
  input  logic [W:0]          a_mag,
  input  logic [W:0]          b_mag,
  input  logic                neg,
  output unit_sts_t           sts,
  output logic signed [W-1:0] res
);

  localparam int MW = W + 1;
  localparam int PW = 2 * MW;
  localparam int CW = $clog2(MW + 1);

  logic                busy_r, fin_r, done_r, neg_r, sh16_r;
  logic [CW-1:0]       cnt_r;
  logic [MW:0]         acc_r;
  logic [MW-1:0]       lo_r, a_r;
  logic signed [W-1:0] res_r;

  logic [MW:0]   sum;
  logic [PW-1:0] prod, shifted, lim, mclip;

  // one partial product per cycle
  assign sum  = acc_r + (lo_r[0] ? {1'b0, a_r} : '0);
  assign prod = {acc_r[MW-1:0], lo_r};

  // final shift, saturate to the signed range, apply sign
  always_comb begin
    shifted = sh16_r ? (prod >> 16) : (prod >> F);
    lim     = (PW'(1) << (W - 1)) - (neg_r ? PW'(0) : PW'(1));
    mclip   = (shifted > lim) ? lim : shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        acc_r  <= '0;
        lo_r   <= b_mag;
        a_r    <= a_mag;
        neg_r  <= neg;
        sh16_r <= ctl.sh16;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= sum >> 1;
        lo_r  <= {sum[0], lo_r[MW-1:1]};
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(MW - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        res_r  <= neg_r ? W'(PW'(0) - mclip) : W'(mclip);
      end
    end
  end

  assign sts.busy = busy_r | fin_r;
  assign sts.done = done_r;
  assign res      = res_r;

endmodule

FILE: src/pwis_div.sv
// bit-serial restoring divider, unsigned magnitude, saturated signed result
module pwis_div import pwis_pkg::*; #(
  parameter int W = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [W+DT_W-1:0]   num,
  input  logic [DT_W-1:0]     den,
  input  logic                neg,
  output unit_sts_t           sts,
  output logic signed [W-1:0] res
);

  localparam int ND = W + DT_W;
  localparam int CW = $clog2(ND + 1);

  logic                busy_r, fin_r, done_r, neg_r;
  logic [CW-1:0]       cnt_r;
  logic [DT_W-1:0]     rem_r, den_r;
  logic [ND-1:0]       quo_r;
  logic signed [W-1:0] res_r;

  logic [DT_W:0] trial, diff;
  logic          ge;
  logic [ND-1:0] lim, mclip;

  // one quotient bit per cycle
  always_comb begin
    trial = {rem_r, quo_r[ND-1]};
    diff  = trial - {1'b0, den_r};
    ge    = trial >= {1'b0, den_r};
    lim   = (ND'(1) << (W - 1)) - (neg_r ? ND'(0) : ND'(1));
    mclip = (quo_r > lim) ? lim : quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= '0;
        quo_r  <= num;
        den_r  <= den;
        neg_r  <= neg;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DT_W-1:0] : trial[DT_W-1:0];
        quo_r <= {quo_r[ND-2:0], ge};
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(ND - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        res_r  <= neg_r ? W'(ND'(0) - mclip) : W'(mclip);
      end
    end
  end

  assign sts.busy = busy_r | fin_r;
  assign sts.done = done_r;
  assign res      = res_r;

endmodule

FILE: src/pid_with_integral_separation_core.sv
// PID controller step with derivative on measurement, integral separation
// and conditional anti-windup, fixed point with DATA_WIDTH bit words.
// in_ch carries mode, target, sample and step_time; one beat on out_ch
// (drive, clamped, bad_step) answers every accepted beat, in order.
// Gains, limits and separation ratio are written through cfg_we/cfg_idx/
// cfg_data while the block is idle; the block itself does not enforce this.
// A clear (mode 1) or a zero step_time skips the serial units and goes from S_IDLE straight to S_EMIT.
// A control step runs on one bit-serial multiplier (three or five products)
// and one bit-serial divider (once for the derivative and once more when the
// integral is scaled).
// One item is in work at a time; in_ch.ready is high while the sequencer idles,
// including while a finished result still waits in the output register.
// A stalled receiver holds the result; a later result waits in the sequencer.
// Reset clears the integral, last sample and primed flag, and loads the
// register defaults (zero gains, limits of +/-1000.0, separation off).
`include "assert_macros.svh"
module pid_with_integral_separation_core import pwis_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int CFG_W = (DATA_WIDTH > RATIO_W) ? DATA_WIDTH : RATIO_W
) (
  input logic                 clk,
  input logic                 rst_n,
  pwis_in_if.sink             in_ch,
  pwis_out_if.source          out_ch,
  input logic                 cfg_we,
  input logic [REG_IDX_W-1:0] cfg_idx,
  input logic [CFG_W-1:0]     cfg_data
);

  localparam int W  = DATA_WIDTH;
  localparam int ND = W + DT_W;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] LIM_RST = W'(64'sd1000 <<< FRAC_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_PROP, S_DPROD, S_DIV, S_THR, S_SEP,
    S_INC, S_INC2, S_SCALE, S_SUM, S_FIN, S_EMIT
  } state_t;

  // saturate a one bit wider value
  function automatic logic signed [W-1:0] sat1(input logic signed [W:0] x);
    logic signed [W-1:0] r;
    if (x > $signed({SMAX[W-1], SMAX}))      r = SMAX;
    else if (x < $signed({SMIN[W-1], SMIN})) r = SMIN;
    else                                     r = x[W-1:0];
    return r;
  endfunction

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    return sat1($signed({a[W-1], a}) + $signed({b[W-1], b}));
  endfunction

  function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    return sat1($signed({a[W-1], a}) - $signed({b[W-1], b}));
  endfunction

  function automatic logic signed [W-1:0] neg_sat(input logic signed [W-1:0] a);
    return (a == SMIN) ? SMAX : -a;
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
    return a[W-1] ? W'(-a) : W'(a);
  endfunction

  // configuration registers
  logic signed [W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic signed [W-1:0] drive_min_r, drive_max_r, accum_min_r, accum_max_r;
  logic [RATIO_W-1:0]  ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      drive_min_r <= -LIM_RST;
      drive_max_r <= LIM_RST;
      accum_min_r <= -LIM_RST;
      accum_max_r <= LIM_RST;
      ratio_r     <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_GAIN_P:    gain_p_r    <= cfg_data[W-1:0];
        REG_GAIN_I:    gain_i_r    <= cfg_data[W-1:0];
        REG_GAIN_D:    gain_d_r    <= cfg_data[W-1:0];
        REG_DRIVE_MIN: drive_min_r <= cfg_data[W-1:0];
        REG_DRIVE_MAX: drive_max_r <= cfg_data[W-1:0];
        REG_ACCUM_MIN: accum_min_r <= cfg_data[W-1:0];
        REG_ACCUM_MAX: accum_max_r <= cfg_data[W-1:0];
        REG_SEP_RATIO: ratio_r     <= cfg_data[RATIO_W-1:0];
      endcase
    end
  end

  // sequencer state and working registers
  state_t              state_r;
  logic                issued_r, primed_r, out_valid_r;
  logic signed [W-1:0] acc_r, last_r;
  logic signed [W-1:0] tgt_r, smp_r, err_r, dsamp_r;
  logic [DT_W-1:0]     dt_r;
  logic signed [W-1:0] prop_r, dprod_r, deriv_r, thr_r, inc_r, ni_r, s1_r;
  logic signed [W-1:0] res_drive_r, out_drive_r;
  logic                res_clamped_r, res_bad_r, out_clamped_r, out_bad_r;

  // shared serial units
  mul_ctl_t            mul_ctl;
  unit_sts_t           mul_sts, div_sts;
  logic [W:0]          mul_a, mul_b;
  logic                mul_neg, div_start, div_neg;
  logic [ND-1:0]       div_num;
  logic [DT_W-1:0]     div_den;
  logic signed [W-1:0] mul_res, div_res;

  logic [RATIO_W-1:0] ratio_c;
  logic               ratio_nz, big_pos, big_neg, hold_c, scale_c;
  logic signed [W-1:0] ni_c, unc_c, drv_c;
  logic               in_fire, out_free;

  assign ratio_c  = (ratio_r > RATIO_ONE) ? RATIO_ONE : ratio_r;
  assign ratio_nz = ratio_c != '0;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // operand selection for the multiplier and divider
  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    mul_neg     = 1'b0;
    mul_ctl     = '0;
    div_num     = '0;
    div_den     = dt_r;
    div_neg     = 1'b0;
    unique case (state_r)
      S_PROP: begin
        mul_a   = {1'b0, mag(gain_p_r)};
        mul_b   = {1'b0, mag(err_r)};
        mul_neg = gain_p_r[W-1] ^ err_r[W-1];
      end
      S_DPROD: begin
        mul_a   = {1'b0, mag(gain_d_r)};
        mul_b   = {1'b0, mag(dsamp_r)};
        mul_neg = gain_d_r[W-1] ^ dsamp_r[W-1];
      end
      S_THR: begin
        mul_a       = {1'b0, mag(tgt_r)};
        mul_b       = (W + 1)'(ratio_c);
        mul_neg     = tgt_r[W-1];
        mul_ctl.sh16 = 1'b1;
      end
      S_INC: begin
        mul_a   = {1'b0, mag(gain_i_r)};
        mul_b   = {1'b0, mag(err_r)};
        mul_neg = gain_i_r[W-1] ^ err_r[W-1];
      end
      S_INC2: begin
        mul_a       = {1'b0, mag(inc_r)};
        mul_b       = (W + 1)'(dt_r);
        mul_neg     = inc_r[W-1];
        mul_ctl.sh16 = 1'b1;
      end
      S_DIV: begin
        div_num = {mag(dprod_r), {DT_W{1'b0}}};
        div_neg = dprod_r[W-1];
      end
      S_SCALE: begin
        div_num = ND'({mag(acc_r), 2'b00});
        div_den = SCALE_DEN;
        div_neg = acc_r[W-1];
      end
      default: ;
    endcase
    mul_ctl.start = !issued_r && (state_r == S_PROP || state_r == S_DPROD ||
                    state_r == S_THR || state_r == S_INC || state_r == S_INC2);
  end

  assign div_start = !issued_r && (state_r == S_DIV || state_r == S_SCALE);

  pwis_mul #(.W(W), .F(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .a_mag (mul_a),
    .b_mag (mul_b),
    .neg   (mul_neg),
    .sts   (mul_sts),
    .res   (mul_res)
  );

  pwis_div #(.W(W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .neg   (div_neg),
    .sts   (div_sts),
    .res   (div_res)
  );

  // separation decision
  always_comb begin
    big_pos = err_r > thr_r;
    big_neg = err_r < -thr_r;
    hold_c  = ratio_nz && ((big_pos && acc_r > 0) || (big_neg && acc_r < 0));
    scale_c = ratio_nz && ((big_pos && acc_r < 0) || (big_neg && acc_r > 0));
  end

  // integral clamp, final sum and output clamp
  always_comb begin
    if (ni_r > accum_max_r)      ni_c = accum_max_r;
    else if (ni_r < accum_min_r) ni_c = accum_min_r;
    else                         ni_c = ni_r;
    unc_c = sat_add(s1_r, deriv_r);
    if (unc_c > drive_max_r)      drv_c = drive_max_r;
    else if (unc_c < drive_min_r) drv_c = drive_min_r;
    else                          drv_c = unc_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      primed_r    <= 1'b0;
      acc_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_EMIT) out_valid_r <= 1'b0;
      if (mul_ctl.start || div_start) issued_r <= 1'b1;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            tgt_r         <= in_ch.target;
            smp_r         <= in_ch.sample;
            dt_r          <= in_ch.step_time;
            err_r         <= sat_sub(in_ch.target, in_ch.sample);
            dsamp_r       <= primed_r ? sat_sub(in_ch.sample, last_r) : '0;
            res_drive_r   <= '0;
            res_clamped_r <= 1'b0;
            res_bad_r     <= 1'b0;
            if (in_ch.mode) begin
              acc_r    <= '0;
              last_r   <= '0;
              primed_r <= 1'b0;
              state_r  <= S_EMIT;
            end else if (in_ch.step_time == '0) begin
              res_bad_r <= 1'b1;
              state_r   <= S_EMIT;
            end else begin
              primed_r <= 1'b1;
              state_r  <= S_PROP;
            end
          end
        end
        S_PROP: if (mul_sts.done) begin
          prop_r   <= mul_res;
          issued_r <= 1'b0;
          state_r  <= S_DPROD;
        end
        S_DPROD: if (mul_sts.done) begin
          dprod_r  <= mul_res;
          issued_r <= 1'b0;
          state_r  <= S_DIV;
        end
        S_DIV: if (div_sts.done) begin
          deriv_r  <= neg_sat(div_res);
          issued_r <= 1'b0;
          state_r  <= S_THR;
        end
        S_THR: if (mul_sts.done) begin
          thr_r    <= mul_res[W-1] ? neg_sat(mul_res) : mul_res;
          issued_r <= 1'b0;
          state_r  <= S_SEP;
        end
        S_SEP: begin
          if (hold_c) begin
            ni_r    <= acc_r;
            state_r <= S_SUM;
          end else if (scale_c) begin
            state_r <= S_SCALE;
          end else begin
            state_r <= S_INC;
          end
        end
        S_INC: if (mul_sts.done) begin
          inc_r    <= mul_res;
          issued_r <= 1'b0;
          state_r  <= S_INC2;
        end
        S_INC2: if (mul_sts.done) begin
          ni_r     <= sat_add(acc_r, mul_res);
          issued_r <= 1'b0;
          state_r  <= S_SUM;
        end
        S_SCALE: if (div_sts.done) begin
          ni_r     <= div_res;
          issued_r <= 1'b0;
          state_r  <= S_SUM;
        end
        S_SUM: begin
          ni_r    <= ni_c;
          s1_r    <= sat_add(prop_r, ni_c);
          state_r <= S_FIN;
        end
        S_FIN: begin
          res_drive_r   <= drv_c;
          res_clamped_r <= (unc_c > drive_max_r) || (unc_c < drive_min_r);
          // anti-windup: keep the old integral while pushing into a limit
          if (!((unc_c > drive_max_r && err_r > 0) ||
                (unc_c < drive_min_r && err_r < 0))) begin
            acc_r <= ni_r;
          end
          last_r  <= smp_r;
          state_r <= S_EMIT;
        end
        S_EMIT: if (out_free) begin
          out_drive_r   <= res_drive_r;
          out_clamped_r <= res_clamped_r;
          out_bad_r     <= res_bad_r;
          out_valid_r   <= 1'b1;
          state_r       <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready     = state_r == S_IDLE;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.drive    = out_drive_r;
  assign out_ch.clamped  = out_clamped_r;
  assign out_ch.bad_step = out_bad_r;

  // a clear drops the primed flag
  `PWIS_ASSERT(a_clear_unprimes, clk, rst_n, in_fire && in_ch.mode |=> !primed_r, "clear left primed")
  // zero step time goes straight to the result with the flag set
  `PWIS_ASSERT(a_bad_step, clk, rst_n, in_fire && !in_ch.mode && in_ch.step_time == '0 |=> state_r == S_EMIT && res_bad_r, "zero step not flagged")
  // a clamped drive sits on one of the drive limits
  `PWIS_ASSERT(a_clamp_limit, clk, rst_n, state_r == S_EMIT && res_clamped_r |-> res_drive_r == drive_max_r || res_drive_r == drive_min_r, "clamped drive off limit")
  // serial units are never restarted while busy
  `PWIS_ASSERT(a_unit_idle, clk, rst_n, (mul_ctl.start |-> !mul_sts.busy) and (div_start |-> !div_sts.busy), "unit restarted while busy")
  // nothing is offered out of reset
  `PWIS_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid_r && state_r == S_IDLE, "output after reset")

endmodule

FILE: verif/pid_with_integral_separation_checker.sv
// watches both channels and the register port, predicts each drive beat
// and compares it with what the block returns
module pid_with_integral_separation_checker import pwis_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  pwis_in_if                   in_mon,
  pwis_out_if                  out_mon,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]          cfg_data,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  typedef struct {
    longint drive;
    bit     clamped;
    bit     bad_step;
  } drive_beat_t;

  drive_beat_t drive_q[$];

  // register copies and controller state
  longint kp, ki, kd, out_lo, out_hi, int_lo, int_hi, sep_ratio;
  longint integral, prev_sample;
  bit     primed;

  function automatic longint sat32(longint x);
    if (x > WMAX) return WMAX;
    if (x < WMIN) return WMIN;
    return x;
  endfunction

  function automatic longint from_mag(logic [63:0] m, bit neg);
    logic [63:0] lim;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (m > lim) m = lim;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // exact product, shifted, truncated toward zero, saturated
  function automatic longint mul_q(longint a, longint b, int sh);
    logic [63:0] ua, ub, p;
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    p = (ua * ub) >> sh;
    return from_mag(p, (a < 0) != (b < 0));
  endfunction

  // (num << 16) / den toward zero, saturated
  function automatic longint div_q(longint num, longint den);
    logic [63:0] m;
    m = (num < 0) ? 64'(-num) : 64'(num);
    return from_mag((m << 16) / 64'(den), num < 0);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic drive_beat_t control_step(bit clr, longint tgt, longint smp, longint dt);
    drive_beat_t r;
    longint err, prop, der, thr, nxt, unc, inc, rat;
    r.drive = 0;
    r.clamped = 0;
    r.bad_step = 0;
    if (clr) begin
      integral = 0;
      prev_sample = 0;
      primed = 0;
      return r;
    end
    if (dt == 0) begin
      r.bad_step = 1;
      return r;
    end
    if (!primed) begin
      prev_sample = smp;
      primed = 1;
    end
    err = sat32(tgt - smp);
    prop = mul_q(kp, err, FRAC_BITS_DEF);
    der = mul_q(kd, sat32(smp - prev_sample), FRAC_BITS_DEF);
    der = sat32(-div_q(der, dt));
    rat = (sep_ratio > 65536) ? 65536 : sep_ratio;
    thr = mul_q(tgt, rat, 16);
    if (thr < 0) thr = sat32(-thr);
    // separation: hold on a large aligned error, scale on a large opposing one
    if (rat != 0 && err > thr && integral > 0) nxt = integral;
    else if (rat != 0 && err < -thr && integral < 0) nxt = integral;
    else if (rat != 0 && ((err > thr && integral < 0) || (err < -thr && integral > 0)))
      nxt = (integral * 4) / 5;
    else begin
      inc = mul_q(ki, err, FRAC_BITS_DEF);
      inc = mul_q(inc, dt, 16);
      nxt = sat32(integral + inc);
    end
    nxt = clip(nxt, int_lo, int_hi);
    unc = sat32(sat32(prop + nxt) + der);
    r.drive = clip(unc, out_lo, out_hi);
    r.clamped = (unc > out_hi) || (unc < out_lo);
    // conditional anti-windup
    if (unc > out_hi && err > 0) nxt = integral;
    else if (unc < out_lo && err < 0) nxt = integral;
    integral = nxt;
    prev_sample = smp;
    return r;
  endfunction

  always @(posedge clk) begin
    drive_beat_t got, want;
    if (!rst_n) begin
      errors = 0;
      kp = 0; ki = 0; kd = 0;
      out_lo = -65536000; out_hi = 65536000;
      int_lo = -65536000; int_hi = 65536000;
      sep_ratio = 0;
      integral = 0; prev_sample = 0; primed = 0;
      drive_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (reg_idx_t'(cfg_idx))
          REG_GAIN_P:    kp = longint'($signed(cfg_data));
          REG_GAIN_I:    ki = longint'($signed(cfg_data));
          REG_GAIN_D:    kd = longint'($signed(cfg_data));
          REG_DRIVE_MIN: out_lo = longint'($signed(cfg_data));
          REG_DRIVE_MAX: out_hi = longint'($signed(cfg_data));
          REG_ACCUM_MIN: int_lo = longint'($signed(cfg_data));
          REG_ACCUM_MAX: int_hi = longint'($signed(cfg_data));
          REG_SEP_RATIO: sep_ratio = longint'(cfg_data[RATIO_W-1:0]);
          default: ;
        endcase
      end
      // accepted request beat
      if (in_mon.valid && in_mon.ready)
        drive_q.push_back(control_step(in_mon.mode, longint'(in_mon.target),
                                       longint'(in_mon.sample), longint'(in_mon.step_time)));
      // accepted drive beat
      if (out_mon.valid && out_mon.ready) begin
        got.drive = longint'(out_mon.drive);
        got.clamped = out_mon.clamped;
        got.bad_step = out_mon.bad_step;
        if (drive_q.size() == 0) begin
          $error("drive beat with nothing expected: drive %0d", got.drive);
          errors++;
        end else begin
          want = drive_q.pop_front();
          if (got.drive != want.drive) begin
            $error("drive: expected %0d, actual %0d", want.drive, got.drive);
            errors++;
          end
          if (got.clamped != want.clamped) begin
            $error("clamped: expected %0d, actual %0d", want.clamped, got.clamped);
            errors++;
          end
          if (got.bad_step != want.bad_step) begin
            $error("bad_step: expected %0d, actual %0d", want.bad_step, got.bad_step);
            errors++;
          end
        end
      end
    end
    pending = drive_q.size();
  end

endmodule

FILE: verif/pid_with_integral_separation_core_tb.sv
module pid_with_integral_separation_core_tb;
  import pwis_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 192;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [31:0] cfg_data;
  int errors, pending;
  int src_idle, sink_idle;
  int n_steps, n_clears, n_bad, n_cfg;
  longint cycles;

  pwis_in_if  in_ch ();
  pwis_out_if out_ch ();

  pid_with_integral_separation_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  pid_with_integral_separation_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // clock
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("** pid_with_integral_separation_core: FAILED **");
        $finish;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= sink_idle);
  end

  // register write, only while idle
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_we = 1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    n_cfg++;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // one request beat; returns at a falling edge with valid still high
  task automatic send(bit clr, logic [31:0] tgt, logic [31:0] smp, logic [15:0] dt);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid = 0;
      @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.mode = clr;
    in_ch.target = tgt;
    in_ch.sample = smp;
    in_ch.step_time = dt;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (clr) n_clears++;
    else if (dt == 0) n_bad++;
    else n_steps++;
  endtask

  function automatic logic [31:0] rand_level();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return 32'($signed($urandom_range(0, 26214400)) - 13107200);
    if (pick < 80) return $urandom;
    case ($urandom_range(4))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'hffffffff;
      default: return 32'h1;
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    if ($urandom_range(9) < 8) return 32'($signed($urandom_range(0, 524288)) - 262144);
    return $urandom;
  endfunction

  // one register setting per phase, extremes on some phases
  task automatic program_phase(int ph);
    logic [31:0] a, b;
    case (ph)
      1: begin
        write_reg(REG_GAIN_P, 32'h7fffffff);
        write_reg(REG_GAIN_I, 32'h80000000);
        write_reg(REG_GAIN_D, 32'h7fffffff);
        write_reg(REG_DRIVE_MIN, 32'h80000000);
        write_reg(REG_DRIVE_MAX, 32'h7fffffff);
        write_reg(REG_ACCUM_MIN, 32'h80000000);
        write_reg(REG_ACCUM_MAX, 32'h7fffffff);
        write_reg(REG_SEP_RATIO, 32'd65536);
      end
      3: begin
        // inverted limits and a ratio above one
        write_reg(REG_GAIN_P, rand_gain());
        write_reg(REG_GAIN_I, rand_gain());
        write_reg(REG_GAIN_D, 32'h80000000);
        write_reg(REG_DRIVE_MIN, 32'd6553600);
        write_reg(REG_DRIVE_MAX, -32'sd6553600);
        write_reg(REG_ACCUM_MIN, 32'd3276800);
        write_reg(REG_ACCUM_MAX, -32'sd3276800);
        write_reg(REG_SEP_RATIO, 32'h1ffff);
      end
      default: begin
        write_reg(REG_GAIN_P, rand_gain());
        write_reg(REG_GAIN_I, rand_gain());
        write_reg(REG_GAIN_D, rand_gain());
        a = $urandom_range(0, 65536000);
        b = $urandom_range(0, 65536000);
        write_reg(REG_DRIVE_MIN, -a);
        write_reg(REG_DRIVE_MAX, b);
        write_reg(REG_ACCUM_MIN, -(a >> 1));
        write_reg(REG_ACCUM_MAX, b >> 1);
        write_reg(REG_SEP_RATIO, (ph == 4) ? 32'd0 : 32'($urandom_range(1, 65536)));
      end
    endcase
  endtask

  initial begin
    logic [31:0] tgt, smp;
    logic [15:0] dt;
    int pick;
    rst_n = 0;
    cfg_we = 0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 0;
    in_ch.mode = 0;
    in_ch.target = '0;
    in_ch.sample = '0;
    in_ch.step_time = '0;
    out_ch.ready = 0;
    n_steps = 0; n_clears = 0; n_bad = 0; n_cfg = 0;
    src_idle = 36;
    sink_idle = 51;
    repeat (8) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: default registers first, then a moderate setting
    send(0, 32'd655360, 32'd0, 16'd6554);
    in_ch.valid = 0;
    drain();
    write_reg(REG_GAIN_P, 32'd65536);
    write_reg(REG_GAIN_I, 32'd32768);
    write_reg(REG_GAIN_D, 32'd6554);
    write_reg(REG_SEP_RATIO, 32'd13107);
    send(1, 32'h7fffffff, 32'h80000000, 16'd0);
    send(0, 32'h7fffffff, 32'h80000000, 16'd65535);
    send(0, 32'h80000000, 32'h7fffffff, 16'd1);
    send(0, 32'd655360, 32'd655360, 16'd0);
    send(0, 32'd6553600, 32'd6488064, 16'd655);
    send(0, 32'd6553600, 32'd6422528, 16'd655);
    send(0, 32'd6553600, 32'd6356992, 16'd655);
    // large aligned error holds, large opposing error scales
    send(0, 32'd6553600, 32'd0, 16'd655);
    send(0, 32'd6553600, 32'd19660800, 16'd655);
    send(0, 32'd6553600, 32'd19660800, 16'd655);
    send(0, 32'd0, 32'hffff0000, 16'd1);
    send(1, 32'd0, 32'd0, 16'd100);
    send(0, 32'h80000000, 32'h80000000, 16'd65535);
    send(0, 32'hffffffff, 32'h1, 16'd1);
    send(0, 32'h0, 32'h7fffffff, 16'd1);
    in_ch.valid = 0;

    for (int ph = 0; ph < PHASES; ph++) begin
      src_idle  = (ph < 2) ? 36 : (ph < 4) ? 51 : 0;
      sink_idle = (ph < 2) ? 51 : (ph < 4) ? 36 : 0;
      drain();
      program_phase(ph);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // hold off until all outstanding drive beats are back
        if (i == PHASE_ITEMS / 2) begin
          in_ch.valid = 0;
          while (pending != 0) @(negedge clk);
        end
        pick = $urandom_range(99);
        tgt = rand_level();
        smp = ($urandom_range(1)) ? tgt + 32'($signed($urandom_range(0, 1310720)) - 655360)
                                  : rand_level();
        dt = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6554));
        if (pick < 5) send(1, $urandom, $urandom, 16'($urandom));
        else if (pick < 9) send(0, $urandom, $urandom, 16'd0);
        else send(0, tgt, smp, (dt == 0) ? 16'd1 : dt);
      end
      in_ch.valid = 0;
    end

    drain();
    repeat (250) @(negedge clk);
    $display("covered %0d control steps, %0d clears, %0d zero time steps, %0d register writes",
             n_steps, n_clears, n_bad, n_cfg);
    $display("six register settings incl. full-scale gains, inverted limits, ratio above one");
    if (errors == 0 && pending == 0) begin
      $display("** pid_with_integral_separation_core: PASSED **");
    end else begin
      if (pending != 0) $error("%0d drive beats never arrived", pending);
      $display("** pid_with_integral_separation_core: FAILED **");
    end
    $finish;
  end
endmodule
